@@ rtl/core/lrast_pkg.sv @@
package lrast_pkg;

    // coordinate width of every input and output field
    localparam int COORD_BITS = 6;

    // signed difference of two coordinates
    localparam int DELTA_W = COORD_BITS + 1;
    // error term: holds 2*minor - 2*major .. 2*minor with a sign
    localparam int ERR_W = COORD_BITS + 3;
    // pixel count of one segment, at most 2^COORD_BITS - 1
    localparam int CNT_W = COORD_BITS;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    // segment queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // one classified segment, ready to walk
    typedef struct packed {
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [CNT_W-1:0]      abs_major;
        logic [CNT_W-1:0]      abs_minor;
        logic                  x_major;
        logic                  step_neg_x;
        logic                  step_neg_y;
        logic [ERR_W-1:0]      err_init;
    } seg_job_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] remaining;
    } walk_status_t;

    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

@@ rtl/core/line_rasterizer_top.sv @@
// Bresenham line rasterizer: each input beat is one segment (start and end
// point, signed), and the block streams out the pixels of that segment, one
// pixel per output beat, from the start point up to but not including the end
// point, |major delta| pixels in all, with tlast on the final one. The major
// axis is the one with the larger absolute delta, y on a tie. A zero-length
// segment produces no output at all. The pixel walker loads each segment in an
// idle state before it walks it, and it emits at most one pixel per cycle,
// fewer while the output is stalled; that sets the throughput. Segments are
// classified on arrival and parked in a two-entry queue, so the input keeps
// taking segments while the walker is still busy, until the queue is full,
// and a registered output stage holds a pixel during backpressure.
module line_rasterizer_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_start, y_start, x_end, y_end from bit 0 up
    input  logic [lrast_pkg::IN_DATA_W-1:0]  s_axis_tdata,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pixel_x, pixel_y from bit 0 up, zero padded
    output logic [lrast_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int CB = lrast_pkg::COORD_BITS;

    // unpacked segment fields
    logic [CB-1:0] x_start;
    logic [CB-1:0] y_start;
    logic [CB-1:0] x_end;
    logic [CB-1:0] y_end;

    lrast_pkg::seg_job_t     push_job;
    lrast_pkg::seg_job_t     head_job;
    lrast_pkg::q_status_t    q_stat;
    lrast_pkg::walk_status_t walk_stat;
    logic                    push;
    logic                    pop;
    logic [CB-1:0]           pixel_x;
    logic [CB-1:0]           pixel_y;

    assign x_start = s_axis_tdata[CB-1:0];
    assign y_start = s_axis_tdata[2*CB-1:CB];
    assign x_end   = s_axis_tdata[3*CB-1:2*CB];
    assign y_end   = s_axis_tdata[4*CB-1:3*CB];

    // front: deltas, axis choice, step signs, initial error term
    lrast_front u_front
    (
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .seg_valid (s_axis_tvalid),
        .seg_ready (s_axis_tready),
        .q_stat    (q_stat),
        .push      (push),
        .job       (push_job)
    );

    // classified segments waiting for the walker
    lrast_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // back: one pixel per cycle through the error-term loop while the output is not stalled
    lrast_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .pix_valid (m_axis_tvalid),
        .pix_ready (m_axis_tready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pix_last  (m_axis_tlast),
        .walk_stat (walk_stat)
    );

    assign m_axis_tdata = {{(lrast_pkg::OUT_DATA_W - 2*CB){1'b0}}, pixel_y, pixel_x};

`ifndef SYNTHESIS
    // queue occupancy never exceeds its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= lrast_pkg::QCNT_W'(lrast_pkg::QUEUE_DEPTH))
        else $error("segment queue overfilled");

    // a zero-length segment never reaches the queue
    a_zero_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && x_start == x_end && y_start == y_end)
        |-> !push)
        else $error("zero-length segment queued");

    // the walker never runs with nothing left to emit
    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        walk_stat.busy |-> (walk_stat.remaining != '0))
        else $error("walker busy with zero pixels left");

    // the final pixel of a run returns the walker to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_stat.busy && walk_stat.remaining == lrast_pkg::CNT_W'(1)
         && (!m_axis_tvalid || m_axis_tready))
        |=> (!walk_stat.busy && m_axis_tvalid && m_axis_tlast))
        else $error("walker did not finish on last pixel");
`endif

endmodule

@@ rtl/core/lrast_front.sv @@
module lrast_front
(
    input  logic [lrast_pkg::COORD_BITS-1:0] x_start,
    input  logic [lrast_pkg::COORD_BITS-1:0] y_start,
    input  logic [lrast_pkg::COORD_BITS-1:0] x_end,
    input  logic [lrast_pkg::COORD_BITS-1:0] y_end,
    input  logic                             seg_valid,
    output logic                             seg_ready,
    input  lrast_pkg::q_status_t             q_stat,
    output logic                             push,
    output lrast_pkg::seg_job_t              job
);

    localparam int CB = lrast_pkg::COORD_BITS;
    localparam int DW = lrast_pkg::DELTA_W;

    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] adx_full;
    logic [DW-1:0] ady_full;
    logic [CB-1:0] adx;
    logic [CB-1:0] ady;
    logic          x_major;
    logic [CB-1:0] major;
    logic [CB-1:0] minor;

    // sign-extended deltas
    assign dx = {x_end[CB-1], x_end} - {x_start[CB-1], x_start};
    assign dy = {y_end[CB-1], y_end} - {y_start[CB-1], y_start};

    assign adx_full = dx[DW-1] ? (~dx + DW'(1)) : dx;
    assign ady_full = dy[DW-1] ? (~dy + DW'(1)) : dy;
    assign adx = adx_full[CB-1:0];
    assign ady = ady_full[CB-1:0];

    // ties go to y
    assign x_major = adx > ady;
    assign major   = x_major ? adx : ady;
    assign minor   = x_major ? ady : adx;

    assign seg_ready = !q_stat.full;

    // zero-length segments are dropped here
    assign push = seg_valid && seg_ready && (major != '0);

    always_comb
    begin
        job.x_start    = x_start;
        job.y_start    = y_start;
        job.abs_major  = major;
        job.abs_minor  = minor;
        job.x_major    = x_major;
        job.step_neg_x = dx[DW-1];
        job.step_neg_y = dy[DW-1];
        job.err_init   = {2'b00, minor, 1'b0} - {3'b000, major};
    end

endmodule

@@ rtl/core/lrast_queue.sv @@
module lrast_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lrast_pkg::seg_job_t  push_job,
    input  logic                 pop,
    output lrast_pkg::seg_job_t  head_job,
    output lrast_pkg::q_status_t q_stat
);

    localparam int DEPTH = lrast_pkg::QUEUE_DEPTH;
    localparam int PW    = lrast_pkg::QPTR_W;
    localparam int CW    = lrast_pkg::QCNT_W;

    lrast_pkg::seg_job_t slot_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign do_push = push && (count_reg != CW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        q_stat.count = count_reg;
        q_stat.full  = (count_reg == CW'(DEPTH));
        q_stat.empty = (count_reg == '0);
    end

endmodule

@@ rtl/core/lrast_back.sv @@
module lrast_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrast_pkg::seg_job_t                 head_job,
    input  lrast_pkg::q_status_t                q_stat,
    output logic                                pop,
    output logic                                pix_valid,
    input  logic                                pix_ready,
    output logic [lrast_pkg::COORD_BITS-1:0]    pixel_x,
    output logic [lrast_pkg::COORD_BITS-1:0]    pixel_y,
    output logic                                pix_last,
    output lrast_pkg::walk_status_t             walk_stat
);

    localparam int CB = lrast_pkg::COORD_BITS;
    localparam int EW = lrast_pkg::ERR_W;
    localparam int NW = lrast_pkg::CNT_W;

    lrast_pkg::walk_state_t state_reg;
    lrast_pkg::walk_state_t state_next;

    logic [CB-1:0] cur_x_reg;
    logic [CB-1:0] cur_y_reg;
    logic [EW-1:0] err_reg;
    logic [EW-1:0] inc_lo_reg;
    logic [EW-1:0] inc_hi_reg;
    logic [NW-1:0] remaining_reg;
    logic          x_major_reg;
    logic          step_neg_x_reg;
    logic          step_neg_y_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CB-1:0] out_x_reg;
    logic [CB-1:0] out_y_reg;
    logic          out_last_reg;

    logic          emit;
    logic          err_neg;
    logic          step_x;
    logic          step_y;
    logic [CB-1:0] delta_x;
    logic [CB-1:0] delta_y;
    logic          final_pix;

    assign err_neg   = err_reg[EW-1];
    assign final_pix = (remaining_reg == NW'(1));
    assign step_x    = x_major_reg || !err_neg;
    assign step_y    = !x_major_reg || !err_neg;
    assign delta_x   = step_neg_x_reg ? '1 : CB'(1);
    assign delta_y   = step_neg_y_reg ? '1 : CB'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrast_pkg::WALK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = lrast_pkg::WALK_RUN;
                end
            end
            lrast_pkg::WALK_RUN:
            begin
                if (emit && final_pix)
                begin
                    state_next = lrast_pkg::WALK_IDLE;
                end
            end
            default:
            begin
                state_next = lrast_pkg::WALK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            lrast_pkg::WALK_IDLE:
            begin
                pop = !q_stat.empty;
            end
            lrast_pkg::WALK_RUN:
            begin
                emit = !out_valid_reg || pix_ready;
            end
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !pix_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrast_pkg::WALK_IDLE;
            out_valid_reg <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                remaining_reg <= head_job.abs_major;
            end
            else if (emit)
            begin
                remaining_reg <= remaining_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_x_reg      <= head_job.x_start;
            cur_y_reg      <= head_job.y_start;
            err_reg        <= head_job.err_init;
            inc_lo_reg     <= {2'b00, head_job.abs_minor, 1'b0};
            inc_hi_reg     <= {2'b00, head_job.abs_minor, 1'b0}
                            - {2'b00, head_job.abs_major, 1'b0};
            x_major_reg    <= head_job.x_major;
            step_neg_x_reg <= head_job.step_neg_x;
            step_neg_y_reg <= head_job.step_neg_y;
        end
        else if (emit)
        begin
            err_reg <= err_reg + (err_neg ? inc_lo_reg : inc_hi_reg);
            if (step_x)
            begin
                cur_x_reg <= cur_x_reg + delta_x;
            end
            if (step_y)
            begin
                cur_y_reg <= cur_y_reg + delta_y;
            end
        end
        if (emit)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_last_reg <= final_pix;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pixel_x   = out_x_reg;
    assign pixel_y   = out_y_reg;
    assign pix_last  = out_last_reg;

    always_comb
    begin
        walk_stat.busy      = (state_reg == lrast_pkg::WALK_RUN);
        walk_stat.remaining = remaining_reg;
    end

endmodule
